### sv/bprrq_pkg.sv
// types and constants shared by the ready queue modules
`timescale 1ns / 1ps

package bprrq_pkg;

  localparam int Levels   = 32;
  localparam int Elements = 64;
  localparam int LevelW   = 5;
  localparam int ElemW    = 6;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [ElemW-1:0]  elem_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_PEEK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_QUEUED      = 2'd1,
    ERR_NOT_QUEUED  = 2'd2,
    ERR_LEVEL_EMPTY = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD_T,
    ST_ADD_W1,
    ST_ADD_W2,
    ST_REM_LINK,
    ST_REM_W,
    ST_LVL_CUR,
    ST_ROT_W,
    ST_HI,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic   next_we;
    elem_t  next_wa;
    elem_t  next_wd;
    elem_t  next_ra;
    logic   prev_we;
    elem_t  prev_wa;
    elem_t  prev_wd;
    elem_t  prev_ra;
    logic   lvl_we;
    elem_t  lvl_wa;
    level_t lvl_wd;
    elem_t  lvl_ra;
    logic   head_we;
    level_t head_wa;
    elem_t  head_wd;
    level_t head_ra;
    logic   cur_we;
    level_t cur_wa;
    elem_t  cur_wd;
    level_t cur_ra;
  } mem_req_t;

  typedef struct packed {
    elem_t  next_rd;
    elem_t  prev_rd;
    level_t lvl_rd;
    elem_t  head_rd;
    elem_t  cur_rd;
  } mem_rsp_t;

  typedef struct packed {
    logic   set;
    logic   clr;
    level_t lv;
  } map_req_t;

  typedef struct packed {
    logic [Levels-1:0] used;
    level_t            hi;
    logic              empty;
  } map_rsp_t;

endpackage

### sv/bprrq_in_if.sv
// request channel: action and operands
`timescale 1ns / 1ps

interface bprrq_in_if;
  import bprrq_pkg::*;

  logic   valid;
  logic   ready;
  logic [1:0] action;
  elem_t  element_id;
  level_t element_priority;
  level_t level;

  modport source (output valid, action, element_id, element_priority, level, input ready);
  modport sink (input valid, action, element_id, element_priority, level, output ready);
endinterface

### sv/bprrq_out_if.sv
// result channel: level cursor, highest element and status
`timescale 1ns / 1ps

interface bprrq_out_if;
  import bprrq_pkg::*;

  logic   valid;
  logic   ready;
  elem_t  level_element;
  logic   level_element_valid;
  elem_t  highest_element;
  level_t highest_level;
  logic   queue_empty;
  logic [1:0] error_code;

  modport source (output valid, level_element, level_element_valid, highest_element,
                  highest_level, queue_empty, error_code, input ready);
  modport sink (input valid, level_element, level_element_valid, highest_element,
                highest_level, queue_empty, error_code, output ready);
endinterface

### sv/bprrq_ram.sv
// simple dual-port memory with registered read
`timescale 1ns / 1ps

module bprrq_ram #(
  parameter int Width = 6,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bprrq_lvlmap.sv
// used-level bitmap with highest-level priority encoder
`timescale 1ns / 1ps

module bprrq_lvlmap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bprrq_pkg::map_req_t req_i,
  output bprrq_pkg::map_rsp_t rsp_o
);
  import bprrq_pkg::*;

  logic [Levels-1:0] used_q, used_d;
  level_t            hi;

  always_comb begin
    used_d = used_q;
    if (req_i.set) begin
      used_d[req_i.lv] = 1'b1;
    end
    if (req_i.clr) begin
      used_d[req_i.lv] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_comb begin
    hi = '0;
    for (int i = 0; i < Levels; i++) begin
      if (used_q[i]) begin
        hi = level_t'(i);
      end
    end
  end

  assign rsp_o.used  = used_q;
  assign rsp_o.hi    = hi;
  assign rsp_o.empty = (used_q == '0);

endmodule

### sv/bprrq_ctrl.sv
// sequencer: reads, modifies and writes back the link and level memories
`timescale 1ns / 1ps

module bprrq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  bprrq_in_if.sink            in_i,
  bprrq_out_if.source         out_o,
  output bprrq_pkg::mem_req_t mem_req_o,
  input  bprrq_pkg::mem_rsp_t mem_rsp_i,
  output bprrq_pkg::map_req_t map_req_o,
  input  bprrq_pkg::map_rsp_t map_rsp_i
);
  import bprrq_pkg::*;

  state_e  state_q, state_d;
  action_e act_q, act_d;
  elem_t   id_q, id_d;
  level_t  prio_q, prio_d;
  level_t  lv_q, lv_d;
  elem_t   h_q, h_d;
  elem_t   t_q, t_d;
  elem_t   nx_q, nx_d;
  elem_t   pv_q, pv_d;
  level_t  rlv_q, rlv_d;
  elem_t   le_q, le_d;
  logic    lev_q, lev_d;
  err_e    err_q, err_d;
  logic [Elements-1:0] queued_q, queued_d;

  logic    out_valid_q, out_valid_d;
  elem_t   o_le_q, o_le_d;
  logic    o_lev_q, o_lev_d;
  elem_t   o_he_q, o_he_d;
  level_t  o_hl_q, o_hl_d;
  logic    o_emp_q, o_emp_d;
  err_e    o_err_q, o_err_d;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    id_d     = id_q;
    prio_d   = prio_q;
    lv_d     = lv_q;
    h_d      = h_q;
    t_d      = t_q;
    nx_d     = nx_q;
    pv_d     = pv_q;
    rlv_d    = rlv_q;
    le_d     = le_q;
    lev_d    = lev_q;
    err_d    = err_q;
    queued_d = queued_q;

    out_valid_d = out_valid_q && !out_o.ready;
    o_le_d  = o_le_q;
    o_lev_d = o_lev_q;
    o_he_d  = o_he_q;
    o_hl_d  = o_hl_q;
    o_emp_d = o_emp_q;
    o_err_d = o_err_q;

    mem_req_o = '0;
    mem_req_o.next_ra = id_q;
    mem_req_o.prev_ra = id_q;
    mem_req_o.lvl_ra  = id_q;
    mem_req_o.head_ra = prio_q;
    mem_req_o.cur_ra  = lv_q;
    map_req_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d   = action_e'(in_i.action);
          id_d    = in_i.element_id;
          prio_d  = in_i.element_priority;
          lv_d    = in_i.level;
          le_d    = '0;
          lev_d   = 1'b0;
          err_d   = ERR_OK;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        unique case (act_q)
          ACT_ADD: begin
            if (queued_q[id_q]) begin
              err_d   = ERR_QUEUED;
              state_d = ST_HI;
            end else if (!map_rsp_i.used[prio_q]) begin
              mem_req_o.head_we = 1'b1;
              mem_req_o.head_wa = prio_q;
              mem_req_o.head_wd = id_q;
              mem_req_o.cur_we  = 1'b1;
              mem_req_o.cur_wa  = prio_q;
              mem_req_o.cur_wd  = id_q;
              mem_req_o.next_we = 1'b1;
              mem_req_o.next_wa = id_q;
              mem_req_o.next_wd = id_q;
              mem_req_o.prev_we = 1'b1;
              mem_req_o.prev_wa = id_q;
              mem_req_o.prev_wd = id_q;
              mem_req_o.lvl_we  = 1'b1;
              mem_req_o.lvl_wa  = id_q;
              mem_req_o.lvl_wd  = prio_q;
              map_req_o.set     = 1'b1;
              map_req_o.lv      = prio_q;
              queued_d[id_q]    = 1'b1;
              state_d           = ST_HI;
            end else begin
              mem_req_o.head_ra = prio_q;
              state_d           = ST_ADD_T;
            end
          end
          ACT_REMOVE: begin
            if (!queued_q[id_q]) begin
              err_d   = ERR_NOT_QUEUED;
              state_d = ST_HI;
            end else begin
              state_d = ST_REM_LINK;
            end
          end
          ACT_ROTATE, ACT_PEEK: begin
            if (!map_rsp_i.used[lv_q]) begin
              err_d   = ERR_LEVEL_EMPTY;
              state_d = ST_HI;
            end else begin
              mem_req_o.cur_ra = lv_q;
              state_d          = ST_LVL_CUR;
            end
          end
          default: state_d = ST_HI;
        endcase
      end
      ST_ADD_T: begin
        h_d               = mem_rsp_i.head_rd;
        mem_req_o.prev_ra = mem_rsp_i.head_rd;
        state_d           = ST_ADD_W1;
      end
      ST_ADD_W1: begin
        t_d               = mem_rsp_i.prev_rd;
        mem_req_o.next_we = 1'b1;
        mem_req_o.next_wa = id_q;
        mem_req_o.next_wd = h_q;
        mem_req_o.prev_we = 1'b1;
        mem_req_o.prev_wa = id_q;
        mem_req_o.prev_wd = mem_rsp_i.prev_rd;
        mem_req_o.lvl_we  = 1'b1;
        mem_req_o.lvl_wa  = id_q;
        mem_req_o.lvl_wd  = prio_q;
        state_d           = ST_ADD_W2;
      end
      ST_ADD_W2: begin
        mem_req_o.next_we = 1'b1;
        mem_req_o.next_wa = t_q;
        mem_req_o.next_wd = id_q;
        mem_req_o.prev_we = 1'b1;
        mem_req_o.prev_wa = h_q;
        mem_req_o.prev_wd = id_q;
        queued_d[id_q]    = 1'b1;
        state_d           = ST_HI;
      end
      ST_REM_LINK: begin
        nx_d  = mem_rsp_i.next_rd;
        pv_d  = mem_rsp_i.prev_rd;
        rlv_d = mem_rsp_i.lvl_rd;
        if (mem_rsp_i.next_rd == id_q) begin
          map_req_o.clr  = 1'b1;
          map_req_o.lv   = mem_rsp_i.lvl_rd;
          queued_d[id_q] = 1'b0;
          state_d        = ST_HI;
        end else begin
          mem_req_o.head_ra = mem_rsp_i.lvl_rd;
          mem_req_o.cur_ra  = mem_rsp_i.lvl_rd;
          state_d           = ST_REM_W;
        end
      end
      ST_REM_W: begin
        if (mem_rsp_i.head_rd == id_q) begin
          mem_req_o.head_we = 1'b1;
          mem_req_o.head_wa = rlv_q;
          mem_req_o.head_wd = nx_q;
        end
        if (mem_rsp_i.cur_rd == id_q) begin
          mem_req_o.cur_we = 1'b1;
          mem_req_o.cur_wa = rlv_q;
          mem_req_o.cur_wd = nx_q;
        end
        mem_req_o.prev_we = 1'b1;
        mem_req_o.prev_wa = nx_q;
        mem_req_o.prev_wd = pv_q;
        mem_req_o.next_we = 1'b1;
        mem_req_o.next_wa = pv_q;
        mem_req_o.next_wd = nx_q;
        queued_d[id_q]    = 1'b0;
        state_d           = ST_HI;
      end
      ST_LVL_CUR: begin
        if (act_q == ACT_PEEK) begin
          le_d    = mem_rsp_i.cur_rd;
          lev_d   = 1'b1;
          state_d = ST_HI;
        end else begin
          mem_req_o.next_ra = mem_rsp_i.cur_rd;
          state_d           = ST_ROT_W;
        end
      end
      ST_ROT_W: begin
        mem_req_o.cur_we = 1'b1;
        mem_req_o.cur_wa = lv_q;
        mem_req_o.cur_wd = mem_rsp_i.next_rd;
        le_d             = mem_rsp_i.next_rd;
        lev_d            = 1'b1;
        state_d          = ST_HI;
      end
      ST_HI: begin
        mem_req_o.cur_ra = map_rsp_i.hi;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        mem_req_o.cur_ra = map_rsp_i.hi;
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_le_d      = le_q;
          o_lev_d     = lev_q;
          o_he_d      = map_rsp_i.empty ? '0 : mem_rsp_i.cur_rd;
          o_hl_d      = map_rsp_i.hi;
          o_emp_d     = map_rsp_i.empty;
          o_err_d     = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      queued_q    <= queued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    id_q    <= id_d;
    prio_q  <= prio_d;
    lv_q    <= lv_d;
    h_q     <= h_d;
    t_q     <= t_d;
    nx_q    <= nx_d;
    pv_q    <= pv_d;
    rlv_q   <= rlv_d;
    le_q    <= le_d;
    lev_q   <= lev_d;
    err_q   <= err_d;
    o_le_q  <= o_le_d;
    o_lev_q <= o_lev_d;
    o_he_q  <= o_he_d;
    o_hl_q  <= o_hl_d;
    o_emp_q <= o_emp_d;
    o_err_q <= o_err_d;
  end

  assign in_i.ready                = (state_q == ST_IDLE);
  assign out_o.valid               = out_valid_q;
  assign out_o.level_element       = o_le_q;
  assign out_o.level_element_valid = o_lev_q;
  assign out_o.highest_element     = o_he_q;
  assign out_o.highest_level       = o_hl_q;
  assign out_o.queue_empty         = o_emp_q;
  assign out_o.error_code          = o_err_q;

endmodule

### sv/bitmap_priority_round_robin_queue.sv
// ready queue top level: sequencer, level bitmap and link memories
// usage:
//   in_i carries one action per beat: add, remove, rotate a level cursor or
//   peek at a level cursor, with element id, priority and level operands.
//   out_o returns one beat per action: the level cursor for rotate and peek,
//   the highest used level and its cursor element, an empty flag and an
//   error code.
// timing:
//   after the request is accepted the sequencer steps through a check, the
//   read, modify and write-back steps of the action on the link memories,
//   a highest-level lookup and the output step that registers the result;
//   it then returns to idle and takes the next request, so a new request
//   is not taken until the current one has been through all of its steps.
//   in_i.ready is high only while the sequencer is idle.
// reset:
//   clears the queued flags, the level bitmap and the output valid; link and
//   level memories are not cleared and are only read for queued entries.
// stall:
//   a held result stays on out_o; the next request is still accepted and
//   waits in its final step until the output register is free.
`timescale 1ns / 1ps

module bitmap_priority_round_robin_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  bprrq_in_if.sink    in_i,
  bprrq_out_if.source out_o
);
  import bprrq_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  map_req_t map_req;
  map_rsp_t map_rsp;

  bprrq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp),
    .map_req_o (map_req),
    .map_rsp_i (map_rsp)
  );

  bprrq_lvlmap u_lvlmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  bprrq_ram #(.Width(ElemW), .Depth(Elements)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.next_we),
    .waddr_i (mem_req.next_wa),
    .wdata_i (mem_req.next_wd),
    .raddr_i (mem_req.next_ra),
    .rdata_o (mem_rsp.next_rd)
  );

  bprrq_ram #(.Width(ElemW), .Depth(Elements)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.prev_we),
    .waddr_i (mem_req.prev_wa),
    .wdata_i (mem_req.prev_wd),
    .raddr_i (mem_req.prev_ra),
    .rdata_o (mem_rsp.prev_rd)
  );

  bprrq_ram #(.Width(LevelW), .Depth(Elements)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.lvl_we),
    .waddr_i (mem_req.lvl_wa),
    .wdata_i (mem_req.lvl_wd),
    .raddr_i (mem_req.lvl_ra),
    .rdata_o (mem_rsp.lvl_rd)
  );

  bprrq_ram #(.Width(ElemW), .Depth(Levels)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.head_we),
    .waddr_i (mem_req.head_wa),
    .wdata_i (mem_req.head_wd),
    .raddr_i (mem_req.head_ra),
    .rdata_o (mem_rsp.head_rd)
  );

  bprrq_ram #(.Width(ElemW), .Depth(Levels)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.cur_we),
    .waddr_i (mem_req.cur_wa),
    .wdata_i (mem_req.cur_wd),
    .raddr_i (mem_req.cur_ra),
    .rdata_o (mem_rsp.cur_rd)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while an action is in progress");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.queue_empty |-> out_o.highest_level == '0 &&
                                         out_o.highest_element == '0)
    else $error("empty queue reports a highest element");

  a_level_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.level_element_valid |-> out_o.error_code == ERR_OK)
    else $error("valid level element with error code");

  a_empty_bitmap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req.set |=> !map_rsp.empty)
    else $error("level bitmap empty after a level was marked used");

endmodule
